// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file dtm_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is active.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/dtm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package dtm_pkg;

    typedef logic [1:0]  func_t;
    typedef logic [5:0]  offset_t;
    typedef logic [31:0] word_t;

    localparam func_t FUNC_IDLE  = 2'd0;
    localparam func_t FUNC_READ  = 2'd1;
    localparam func_t FUNC_WRITE = 2'd2;

    localparam offset_t OFS_FREE   = 6'h00;
    localparam offset_t OFS_MATCHC = 6'h04;
    localparam offset_t OFS_MATCHV = 6'h14;
    localparam offset_t OFS_CTRL   = 6'h20;
    localparam offset_t OFS_STATUS = 6'h24;

    localparam int CTRL_ENABLE_BIT = 1;
    localparam int IRQ_BIT         = 10;
    localparam int FIRQ_BIT        = 11;

    localparam word_t MATCH_RESET = 32'hFFFF_FFFF;

endpackage

`default_nettype wire

// ===== rtl/dual_timer_match_interrupt_block.sv =====
`timescale 1ns / 1ps
`default_nettype none
// An input beat passes through the input register, then the result register.
// Throughput: one beat per cycle while out_ready does not stall; the counters
// advance once per accepted beat. Reset (rst_n low, asynchronous): counters, control
// and status clear, match value goes to all ones, and both pipeline stages are emptied.

module dual_timer_match_interrupt_block (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire dtm_pkg::func_t       func,
    input  wire dtm_pkg::offset_t     reg_offset,
    input  wire dtm_pkg::word_t       write_data,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output dtm_pkg::word_t            bus_rdata,
    output logic                      irq,
    output logic                      firq
);

    logic             stage_valid_reg;
    dtm_pkg::func_t   stage_func_reg;
    dtm_pkg::offset_t stage_offset_reg;
    dtm_pkg::word_t   stage_wdata_reg;

    logic             out_valid_reg;
    dtm_pkg::word_t   out_rdata_reg;
    logic             out_irq_reg;
    logic             out_firq_reg;

    dtm_pkg::word_t   free_reg;
    dtm_pkg::word_t   free_next;
    dtm_pkg::word_t   matchc_reg;
    dtm_pkg::word_t   matchc_next;
    dtm_pkg::word_t   matchv_reg;
    dtm_pkg::word_t   matchv_next;
    dtm_pkg::word_t   ctrl_reg;
    dtm_pkg::word_t   ctrl_next;
    logic [1:0]       status_reg;
    logic [1:0]       status_next;

    dtm_pkg::word_t   matchc_cnt;
    logic [1:0]       status_cnt;
    dtm_pkg::word_t   status_word;
    dtm_pkg::word_t   rdata_next;
    logic             irq_next;
    logic             firq_next;
    logic             advance;
    logic             fire;

    assign advance  = !out_valid_reg || out_ready;
    assign fire     = stage_valid_reg && advance;
    assign in_ready = !stage_valid_reg || advance;

    always_comb
    begin
        free_next = free_reg + 32'd1;
        if (ctrl_reg[dtm_pkg::CTRL_ENABLE_BIT] && (matchc_reg >= matchv_reg))
        begin
            matchc_cnt = '0;
            status_cnt = 2'b11;
        end
        else
        begin
            matchc_cnt = matchc_reg + 32'd1;
            status_cnt = status_reg;
        end

        status_word = '0;
        status_word[dtm_pkg::IRQ_BIT]  = status_cnt[0];
        status_word[dtm_pkg::FIRQ_BIT] = status_cnt[1];

        irq_next  = ctrl_reg[dtm_pkg::IRQ_BIT] && status_cnt[0];
        firq_next = ctrl_reg[dtm_pkg::FIRQ_BIT] && status_cnt[1];

        matchc_next = matchc_cnt;
        matchv_next = matchv_reg;
        ctrl_next   = ctrl_reg;
        status_next = status_cnt;
        rdata_next  = '0;

        case (stage_func_reg)
            dtm_pkg::FUNC_READ:
            begin
                case (stage_offset_reg)
                    dtm_pkg::OFS_FREE:   rdata_next = free_next;
                    dtm_pkg::OFS_MATCHC: rdata_next = matchc_cnt;
                    dtm_pkg::OFS_MATCHV: rdata_next = matchv_reg;
                    dtm_pkg::OFS_CTRL:   rdata_next = ctrl_reg;
                    dtm_pkg::OFS_STATUS: rdata_next = status_word;
                    default:             rdata_next = '0;
                endcase
            end
            dtm_pkg::FUNC_WRITE:
            begin
                case (stage_offset_reg)
                    dtm_pkg::OFS_MATCHV:
                    begin
                        matchv_next = stage_wdata_reg;
                    end
                    dtm_pkg::OFS_CTRL:
                    begin
                        ctrl_next = stage_wdata_reg;
                        if (stage_wdata_reg[dtm_pkg::CTRL_ENABLE_BIT])
                        begin
                            matchc_next = '0;
                            status_next = 2'b00;
                        end
                    end
                    dtm_pkg::OFS_STATUS:
                    begin
                        status_next = status_cnt & ~{stage_wdata_reg[dtm_pkg::FIRQ_BIT],
                                                     stage_wdata_reg[dtm_pkg::IRQ_BIT]};
                    end
                    default:
                    begin
                        matchv_next = matchv_reg;
                    end
                endcase
            end
            default:
            begin
                rdata_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
            free_reg        <= '0;
            matchc_reg      <= '0;
            matchv_reg      <= dtm_pkg::MATCH_RESET;
            ctrl_reg        <= '0;
            status_reg      <= 2'b00;
        end
        else
        begin
            if (in_ready)
            begin
                stage_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= stage_valid_reg;
            end
            if (fire)
            begin
                free_reg   <= free_next;
                matchc_reg <= matchc_next;
                matchv_reg <= matchv_next;
                ctrl_reg   <= ctrl_next;
                status_reg <= status_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            stage_func_reg   <= func;
            stage_offset_reg <= reg_offset;
            stage_wdata_reg  <= write_data;
        end
        if (fire)
        begin
            out_rdata_reg <= rdata_next;
            out_irq_reg   <= irq_next;
            out_firq_reg  <= firq_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign bus_rdata = out_rdata_reg;
    assign irq       = out_irq_reg;
    assign firq      = out_firq_reg;

endmodule

`default_nettype wire

// ===== rtl/dtm_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module dtm_checker (
    input wire logic           clk,
    input wire logic           rst_n,
    input wire logic           in_valid,
    input wire logic           in_ready,
    input wire logic           out_valid,
    input wire logic           out_ready,
    input wire dtm_pkg::word_t bus_rdata
);

    // With no result waiting, the block always takes a new beat.
    `ASSERT_IMPLIES(a_ready_when_empty, clk, rst_n, !out_valid, in_ready)

    // An accepted beat moves through the input register and shows up as a result when the sink is ready.
    `ASSERT_NEXT(a_latency, clk, rst_n, (in_valid && in_ready) ##1 out_ready, out_valid)

    // A stalled result keeps its data.
    `ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(bus_rdata))

endmodule

bind dual_timer_match_interrupt_block dtm_checker u_dtm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .bus_rdata (bus_rdata)
);

`default_nettype wire
